// ===== design/dfvs_pkg.sv =====
// Package for the DWARF 5 form value skipper.
// Holds form codes, status codes, register indexes, shared types and the form decoder.
// No dependencies.
package dfvs_pkg;

  localparam int unsigned LenW = 33;
  localparam int unsigned RemW = 32;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 4;

  // register indexes
  localparam logic [CfgAddrW-1:0] CFG_ADDRESS_SIZE = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_OFFSETS_64 = 2'd1;
  localparam logic [CfgAddrW-1:0] CFG_BIG_ENDIAN = 2'd2;

  // DWARF 5 form codes
  localparam logic [7:0] FORM_ADDR = 8'h01;
  localparam logic [7:0] FORM_BLOCK2 = 8'h03;
  localparam logic [7:0] FORM_BLOCK4 = 8'h04;
  localparam logic [7:0] FORM_DATA2 = 8'h05;
  localparam logic [7:0] FORM_DATA4 = 8'h06;
  localparam logic [7:0] FORM_DATA8 = 8'h07;
  localparam logic [7:0] FORM_STRING = 8'h08;
  localparam logic [7:0] FORM_BLOCK = 8'h09;
  localparam logic [7:0] FORM_BLOCK1 = 8'h0a;
  localparam logic [7:0] FORM_DATA1 = 8'h0b;
  localparam logic [7:0] FORM_FLAG = 8'h0c;
  localparam logic [7:0] FORM_SDATA = 8'h0d;
  localparam logic [7:0] FORM_STRP = 8'h0e;
  localparam logic [7:0] FORM_UDATA = 8'h0f;
  localparam logic [7:0] FORM_REF_ADDR = 8'h10;
  localparam logic [7:0] FORM_REF1 = 8'h11;
  localparam logic [7:0] FORM_REF2 = 8'h12;
  localparam logic [7:0] FORM_REF4 = 8'h13;
  localparam logic [7:0] FORM_REF8 = 8'h14;
  localparam logic [7:0] FORM_REF_UDATA = 8'h15;
  localparam logic [7:0] FORM_INDIRECT = 8'h16;
  localparam logic [7:0] FORM_SEC_OFFSET = 8'h17;
  localparam logic [7:0] FORM_EXPRLOC = 8'h18;
  localparam logic [7:0] FORM_FLAG_PRESENT = 8'h19;
  localparam logic [7:0] FORM_STRX = 8'h1a;
  localparam logic [7:0] FORM_ADDRX = 8'h1b;
  localparam logic [7:0] FORM_REF_SUP4 = 8'h1c;
  localparam logic [7:0] FORM_STRP_SUP = 8'h1d;
  localparam logic [7:0] FORM_DATA16 = 8'h1e;
  localparam logic [7:0] FORM_LINE_STRP = 8'h1f;
  localparam logic [7:0] FORM_REF_SIG8 = 8'h20;
  localparam logic [7:0] FORM_IMPLICIT_CONST = 8'h21;
  localparam logic [7:0] FORM_LOCLISTX = 8'h22;
  localparam logic [7:0] FORM_RNGLISTX = 8'h23;
  localparam logic [7:0] FORM_REF_SUP8 = 8'h24;
  localparam logic [7:0] FORM_STRX1 = 8'h25;
  localparam logic [7:0] FORM_STRX2 = 8'h26;
  localparam logic [7:0] FORM_STRX3 = 8'h27;
  localparam logic [7:0] FORM_STRX4 = 8'h28;
  localparam logic [7:0] FORM_ADDRX1 = 8'h29;
  localparam logic [7:0] FORM_ADDRX2 = 8'h2a;
  localparam logic [7:0] FORM_ADDRX3 = 8'h2b;
  localparam logic [7:0] FORM_ADDRX4 = 8'h2c;

  localparam logic [4:0] DATA16_BYTES = 5'd16;

  typedef enum logic [2:0] {
    ST_NEED     = 3'd0,
    ST_DONE     = 3'd1,
    ST_UNKNOWN  = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_TOOLARGE = 3'd4,
    ST_IDLE     = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    FK_FIXED,
    FK_BLEN_FIXED,
    FK_BLEN_ULEB,
    FK_LEB,
    FK_STRING,
    FK_INDIRECT,
    FK_UNKNOWN
  } form_kind_e;

  typedef struct packed {
    logic [3:0] address_size;
    logic       offsets_64;
    logic       big_endian;
  } cfg_t;

  typedef struct packed {
    logic       action;
    logic [7:0] form_code;
    logic [7:0] data_byte;
    logic       section_end;
  } item_t;

  typedef struct packed {
    status_e         status;
    logic [LenW-1:0] value_length;
  } result_t;

  typedef struct packed {
    form_kind_e kind;
    logic [4:0] count;  // fixed byte count, or length-field bytes for fixed block lengths
  } form_dec_t;

  function automatic form_dec_t form_decode(logic [7:0] code, cfg_t cfg);
    form_dec_t d;
    d.kind = FK_FIXED;
    d.count = 5'd0;
    unique case (code)
      FORM_ADDR: d.count = {1'b0, cfg.address_size};
      FORM_STRP, FORM_REF_ADDR, FORM_SEC_OFFSET, FORM_STRP_SUP, FORM_LINE_STRP:
        d.count = cfg.offsets_64 ? 5'd8 : 5'd4;
      FORM_BLOCK1: begin
        d.kind = FK_BLEN_FIXED;
        d.count = 5'd1;
      end
      FORM_BLOCK2: begin
        d.kind = FK_BLEN_FIXED;
        d.count = 5'd2;
      end
      FORM_BLOCK4: begin
        d.kind = FK_BLEN_FIXED;
        d.count = 5'd4;
      end
      FORM_BLOCK, FORM_EXPRLOC: d.kind = FK_BLEN_ULEB;
      FORM_FLAG_PRESENT, FORM_IMPLICIT_CONST: d.count = 5'd0;
      FORM_FLAG, FORM_DATA1, FORM_REF1, FORM_STRX1, FORM_ADDRX1: d.count = 5'd1;
      FORM_DATA2, FORM_REF2, FORM_STRX2, FORM_ADDRX2: d.count = 5'd2;
      FORM_STRX3, FORM_ADDRX3: d.count = 5'd3;
      FORM_DATA4, FORM_REF4, FORM_STRX4, FORM_ADDRX4, FORM_REF_SUP4: d.count = 5'd4;
      FORM_DATA8, FORM_REF8, FORM_REF_SIG8, FORM_REF_SUP8: d.count = 5'd8;
      FORM_DATA16: d.count = DATA16_BYTES;
      FORM_SDATA, FORM_UDATA, FORM_REF_UDATA, FORM_STRX, FORM_ADDRX,
      FORM_LOCLISTX, FORM_RNGLISTX: d.kind = FK_LEB;
      FORM_STRING: d.kind = FK_STRING;
      FORM_INDIRECT: d.kind = FK_INDIRECT;
      default: d.kind = FK_UNKNOWN;
    endcase
    return d;
  endfunction

endpackage

// ===== design/dfvs_in_reg.sv =====
// Input stage of the form value skipper: registers one accepted transfer.
// Depends on dfvs_pkg.
module dfvs_in_reg
  import dfvs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  advance_i,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_o = valid_q;
  assign item_o = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== design/dfvs_step.sv =====
// Per-item state update of the form value skipper: walk state and next-state logic.
// Depends on dfvs_pkg (form decoder, status codes, types).
module dfvs_step
  import dfvs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    enable_i,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  output result_t result_o
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_FIXED,
    PH_BLEN_FIXED,
    PH_BLEN_ULEB,
    PH_BODY,
    PH_LEB,
    PH_STRING,
    PH_INDIRECT
  } phase_e;

  localparam logic [LenW-1:0] LEN_SAT = {1'b1, {(LenW-1){1'b0}}};
  localparam logic [LenW-1:0] CNT_MAX = {LenW{1'b1}};

  phase_e          phase_q, phase_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [LenW-1:0] acc_q, acc_d;
  logic [5:0]      shift_q, shift_d;
  logic [2:0]      lbl_q, lbl_d;
  logic [LenW-1:0] cnt_q, cnt_d;

  status_e         status;
  logic            do_begin;
  logic [7:0]      begin_code;
  form_dec_t       dec;
  logic [RemW-1:0] rem_dec;
  logic [LenW-1:0] acc_u, acc_f;
  logic [38:0]     uleb_or;
  logic [6:0]      shift_sum;
  logic [5:0]      shift_u;
  logic [2:0]      lbl_dec;
  logic            uleb_last;

  // ULEB128 accumulate, saturating above 32 bits
  always_comb begin
    uleb_or = {6'd0, acc_q} | ({32'd0, item_i.data_byte[6:0]} << shift_q[4:0]);
    acc_u = acc_q;
    if (item_i.data_byte[6:0] != 7'd0) begin
      if (shift_q >= 6'd32 || uleb_or[38:32] != 7'd0) begin
        acc_u = LEN_SAT;
      end else begin
        acc_u = uleb_or[LenW-1:0];
      end
    end
    shift_sum = {1'b0, shift_q} + 7'd7;
    shift_u = shift_sum[6] ? 6'd63 : shift_sum[5:0];
    uleb_last = !item_i.data_byte[7];
  end

  // fixed-width block length byte
  always_comb begin
    if (cfg_i.big_endian) begin
      acc_f = {1'b0, acc_q[23:0], item_i.data_byte};
    end else if (shift_q < 6'd32) begin
      acc_f = acc_q | ({25'd0, item_i.data_byte} << shift_q[4:0]);
    end else begin
      acc_f = acc_q;
    end
  end

  assign rem_dec = (rem_q != '0) ? rem_q - 1'b1 : rem_q;
  assign lbl_dec = (lbl_q != 3'd0) ? lbl_q - 3'd1 : lbl_q;

  always_comb begin
    phase_d = phase_q;
    rem_d = rem_q;
    acc_d = acc_q;
    shift_d = shift_q;
    lbl_d = lbl_q;
    cnt_d = cnt_q;
    status = ST_NEED;
    do_begin = 1'b0;
    begin_code = item_i.form_code;

    if (!item_i.action) begin
      cnt_d = '0;
      rem_d = '0;
      acc_d = '0;
      shift_d = '0;
      lbl_d = '0;
      do_begin = 1'b1;
    end else if (phase_q == PH_IDLE) begin
      status = ST_IDLE;
    end else if (item_i.section_end) begin
      phase_d = PH_IDLE;
      status = ST_TRUNC;
    end else begin
      if (cnt_q != CNT_MAX) begin
        cnt_d = cnt_q + 1'b1;
      end
      unique case (phase_q)
        PH_FIXED, PH_BODY: begin
          rem_d = rem_dec;
          if (rem_dec == '0) begin
            phase_d = PH_IDLE;
            status = ST_DONE;
          end
        end
        PH_BLEN_FIXED: begin
          acc_d = acc_f;
          shift_d = shift_q + 6'd8;
          lbl_d = lbl_dec;
          if (lbl_dec == 3'd0) begin
            if (acc_f == '0) begin
              phase_d = PH_IDLE;
              status = ST_DONE;
            end else begin
              phase_d = PH_BODY;
              rem_d = acc_f[RemW-1:0];
            end
          end
        end
        PH_BLEN_ULEB: begin
          acc_d = acc_u;
          shift_d = shift_u;
          if (uleb_last) begin
            if (acc_u[LenW-1]) begin
              phase_d = PH_IDLE;
              status = ST_TOOLARGE;
            end else if (acc_u == '0) begin
              phase_d = PH_IDLE;
              status = ST_DONE;
            end else begin
              phase_d = PH_BODY;
              rem_d = acc_u[RemW-1:0];
            end
          end
        end
        PH_LEB: begin
          if (!item_i.data_byte[7]) begin
            phase_d = PH_IDLE;
            status = ST_DONE;
          end
        end
        PH_STRING: begin
          if (item_i.data_byte == 8'd0) begin
            phase_d = PH_IDLE;
            status = ST_DONE;
          end
        end
        PH_INDIRECT: begin
          acc_d = acc_u;
          shift_d = shift_u;
          if (uleb_last) begin
            if (acc_u[LenW-1:8] != '0) begin
              phase_d = PH_IDLE;
              status = ST_UNKNOWN;
            end else begin
              do_begin = 1'b1;
              begin_code = acc_u[7:0];
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
          status = ST_IDLE;
        end
      endcase
    end

    dec = form_decode(begin_code, cfg_i);
    if (do_begin) begin
      status = ST_NEED;
      unique case (dec.kind)
        FK_FIXED: begin
          if (dec.count == 5'd0) begin
            phase_d = PH_IDLE;
            status = ST_DONE;
          end else begin
            phase_d = PH_FIXED;
            rem_d = {{(RemW-5){1'b0}}, dec.count};
          end
        end
        FK_BLEN_FIXED: begin
          phase_d = PH_BLEN_FIXED;
          acc_d = '0;
          shift_d = '0;
          lbl_d = dec.count[2:0];
        end
        FK_BLEN_ULEB: begin
          phase_d = PH_BLEN_ULEB;
          acc_d = '0;
          shift_d = '0;
        end
        FK_LEB: phase_d = PH_LEB;
        FK_STRING: phase_d = PH_STRING;
        FK_INDIRECT: begin
          phase_d = PH_INDIRECT;
          acc_d = '0;
          shift_d = '0;
        end
        default: begin
          phase_d = PH_IDLE;
          status = ST_UNKNOWN;
        end
      endcase
    end
  end

  assign result_o.status = status;
  assign result_o.value_length = (status == ST_IDLE) ? '0 : cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      rem_q <= '0;
      acc_q <= '0;
      shift_q <= '0;
      lbl_q <= '0;
      cnt_q <= '0;
    end else if (enable_i) begin
      phase_q <= phase_d;
      rem_q <= rem_d;
      acc_q <= acc_d;
      shift_q <= shift_d;
      lbl_q <= lbl_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== design/dfvs_out_reg.sv =====
// Result register of the form value skipper; holds a result until the sink takes it.
// Depends on dfvs_pkg.
module dfvs_out_reg
  import dfvs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  output logic    free_o,
  input  result_t result_i,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t result_o
);

  logic    valid_q;
  result_t result_q;

  assign free_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

// ===== design/dwarf_form_value_skipper_unit.sv =====
// DWARF 5 form value skipper, top level.
// Usage: the slave stream carries start transfers (tuser bit 0 low, form code in
// tdata[7:0]) and byte transfers (tuser bit 0 high, section byte in tdata[15:8],
// tuser bit 1 high when the section has ended). Every accepted transfer yields
// exactly one result on the master stream: a status code in tdata[2:0] and the
// bytes of the value consumed so far in tdata[35:3].
// Path: a result reaches the master stream through the input register, then the
// result register. Throughput: one transfer per cycle while the master side takes
// results, set by the combinational update of the walk state between the two registers.
// Stall: while the master side holds tready low, one result waits in the result
// register and one transfer in the input register; then s_axis_tready drops.
// Reset: walk state idle, no results pending, address size 8, 32-bit offsets,
// little-endian block lengths. Registers are written through cfg_we_i with
// index 0 address size, 1 offset format, 2 byte order; write only when idle.
// Depends on dfvs_pkg, dfvs_in_reg, dfvs_step, dfvs_out_reg.
module dwarf_form_value_skipper_unit
  import dfvs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // form_code, data_byte
  input  logic [1:0]          s_axis_tuser,   // action, section_end
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [39:0]         m_axis_tdata    // status, value_length, zero fill
);

  cfg_t    cfg_q;
  item_t   in_item, reg_item;
  logic    in_valid, advance, out_free;
  result_t step_result, out_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.address_size <= 4'd8;
      cfg_q.offsets_64 <= 1'b0;
      cfg_q.big_endian <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_ADDRESS_SIZE: cfg_q.address_size <= cfg_wdata_i[3:0];
        CFG_OFFSETS_64: cfg_q.offsets_64 <= cfg_wdata_i[0];
        CFG_BIG_ENDIAN: cfg_q.big_endian <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign in_item.action = s_axis_tuser[0];
  assign in_item.section_end = s_axis_tuser[1];
  assign in_item.form_code = s_axis_tdata[7:0];
  assign in_item.data_byte = s_axis_tdata[15:8];

  assign advance = in_valid && out_free;

  dfvs_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .valid_o   (in_valid),
    .advance_i (advance),
    .item_o    (reg_item)
  );

  dfvs_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .enable_i (advance),
    .cfg_i    (cfg_q),
    .item_i   (reg_item),
    .result_o (step_result)
  );

  dfvs_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .free_o   (out_free),
    .result_i (step_result),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_result)
  );

  assign m_axis_tdata = {4'd0, out_result.value_length, out_result.status};

endmodule
